// ----- sv/lcdnw_pkg.sv -----
// ----------------------------------------------------------------------------
// lcdnw_pkg
// Shared types, register indexes and phase tables for the 4-bit display
// link sequencer.
// ----------------------------------------------------------------------------
package lcdnw_pkg;

    localparam int TICK_W = 20;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POWERUP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_GAP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAP        = 3'd5;

    localparam logic [TICK_W-1:0] RST_PULSE     = 20'd1000;
    localparam logic [TICK_W-1:0] RST_SETTLE    = 20'd2000;
    localparam logic [TICK_W-1:0] RST_LONG      = 20'd50000;
    localparam logic [TICK_W-1:0] RST_POWERUP   = 20'd100000;
    localparam logic [TICK_W-1:0] RST_FIRST_GAP = 20'd20000;
    localparam logic [TICK_W-1:0] RST_GAP       = 20'd5000;

    localparam logic [7:0] CMD_CLEAR   = 8'h01;
    localparam logic [7:0] CMD_HOME    = 8'h02;
    localparam logic [7:0] CMD_SET_DDR = 8'h80;
    localparam logic [3:0] NIB_WAKE    = 4'h3;
    localparam logic [3:0] NIB_4BIT    = 4'h2;

    localparam logic [7:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h14, 8'h54};
    localparam logic [7:0] INIT_CMDS [4] = '{8'h28, 8'h0C, 8'h01, 8'h06};

    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 6'd4;
    localparam logic [STEP_W-1:0] INIT_LAST_STEP = 6'd32;

    typedef enum logic [1:0] {
        REQ_COMMAND = 2'd0,
        REQ_DATA    = 2'd1,
        REQ_CURSOR  = 2'd2,
        REQ_INIT    = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        JOB_BYTE,
        JOB_INIT,
        JOB_ERROR
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic       rs;
        logic [7:0] value;
    } job_t;

    typedef enum logic [2:0] {
        HOLD_ZERO,
        HOLD_PULSE,
        HOLD_SETTLE,
        HOLD_LONG,
        HOLD_POWERUP,
        HOLD_FIRST_GAP,
        HOLD_GAP
    } hold_sel_t;

    typedef struct packed {
        logic       rs;
        logic [3:0] nibble;
        logic       en;
        hold_sel_t  hold_sel;
    } phase_t;

    typedef struct packed {
        logic [TICK_W-1:0] pulse;
        logic [TICK_W-1:0] settle;
        logic [TICK_W-1:0] long_settle;
        logic [TICK_W-1:0] powerup;
        logic [TICK_W-1:0] first_gap;
        logic [TICK_W-1:0] gap;
    } cfg_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } back_state_t;

    // One of the five phases of a byte: two phases per nibble (enable high, then low), then settle.
    function automatic phase_t byte_phase(input logic rs, input logic [7:0] value,
                                          input logic [2:0] sub);
        phase_t p;
        p.rs = rs;
        case (sub)
            3'd0:
            begin
                p.nibble = value[7:4]; p.en = 1'b1; p.hold_sel = HOLD_PULSE;
            end
            3'd1:
            begin
                p.nibble = value[7:4]; p.en = 1'b0; p.hold_sel = HOLD_PULSE;
            end
            3'd2:
            begin
                p.nibble = value[3:0]; p.en = 1'b1; p.hold_sel = HOLD_PULSE;
            end
            3'd3:
            begin
                p.nibble = value[3:0]; p.en = 1'b0; p.hold_sel = HOLD_PULSE;
            end
            default:
            begin
                p.nibble = value[3:0];
                p.en     = 1'b0;
                if (!rs && (value inside {CMD_CLEAR, CMD_HOME}))
                    p.hold_sel = HOLD_LONG;
                else
                    p.hold_sel = HOLD_SETTLE;
            end
        endcase
        return p;
    endfunction

    // Power-up sequence: wait, three wake nibbles and the 4-bit nibble with gaps, four setup bytes.
    function automatic phase_t init_phase(input logic [STEP_W-1:0] step);
        phase_t              p;
        logic [STEP_W-1:0]   rel;
        logic [1:0]          bidx;
        logic [2:0]          sub;
        p    = '{rs: 1'b0, nibble: 4'h0, en: 1'b0, hold_sel: HOLD_POWERUP};
        rel  = step - 6'd13;
        bidx = 2'd0;
        sub  = 3'd0;
        if (step == 6'd0)
        begin
            p.hold_sel = HOLD_POWERUP;
        end
        else if (step <= 6'd12)
        begin
            p.nibble = (step >= 6'd10) ? NIB_4BIT : NIB_WAKE;
            case (step)
                6'd1, 6'd4, 6'd7, 6'd10:
                begin
                    p.en = 1'b1; p.hold_sel = HOLD_PULSE;
                end
                6'd2, 6'd5, 6'd8, 6'd11:
                begin
                    p.en = 1'b0; p.hold_sel = HOLD_PULSE;
                end
                6'd3:    p.hold_sel = HOLD_FIRST_GAP;
                default: p.hold_sel = HOLD_GAP;
            endcase
        end
        else
        begin
            if (rel < 6'd5)
            begin
                bidx = 2'd0; sub = rel[2:0];
            end
            else if (rel < 6'd10)
            begin
                bidx = 2'd1; sub = 3'(rel - 6'd5);
            end
            else if (rel < 6'd15)
            begin
                bidx = 2'd2; sub = 3'(rel - 6'd10);
            end
            else
            begin
                bidx = 2'd3; sub = 3'(rel - 6'd15);
            end
            p = byte_phase(1'b0, INIT_CMDS[bidx], sub);
        end
        return p;
    endfunction

endpackage

// ----- sv/lcdnw_front.sv -----
// ----------------------------------------------------------------------------
// lcdnw_front
// Accepts requests and turns each into a job: a byte to send, the power-up
// sequence, or a cursor error.
// ----------------------------------------------------------------------------
module lcdnw_front #(
    parameter int ROWS    = 2,
    parameter int COLUMNS = 16
) (
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           req_type,
    input  logic [7:0]           byte_value,
    input  logic [2:0]           row,
    input  logic [5:0]           column,
    output logic                 push,
    output lcdnw_pkg::job_t      push_job,
    input  logic                 full
);
    import lcdnw_pkg::*;

    localparam logic [2:0] ROWS_L    = 3'(ROWS);
    localparam logic [5:0] COLUMNS_L = 6'(COLUMNS);

    logic       bad_pos;
    logic [6:0] addr;

    assign bad_pos  = (row >= ROWS_L) || (row > 3'd3) || (column >= COLUMNS_L);
    assign addr     = 7'(ROW_BASE[row[1:0]] + {2'b00, column});
    assign in_stall = full;
    assign push     = in_valid && !full;

    always_comb
    begin
        push_job = '{kind: JOB_BYTE, rs: 1'b0, value: byte_value};
        case (req_kind_t'(req_type))
            REQ_COMMAND: push_job = '{kind: JOB_BYTE, rs: 1'b0, value: byte_value};
            REQ_DATA:    push_job = '{kind: JOB_BYTE, rs: 1'b1, value: byte_value};
            REQ_CURSOR:
            begin
                if (bad_pos)
                    push_job = '{kind: JOB_ERROR, rs: 1'b0, value: 8'h00};
                else
                    push_job = '{kind: JOB_BYTE, rs: 1'b0,
                                 value: CMD_SET_DDR | {1'b0, addr}};
            end
            REQ_INIT:    push_job = '{kind: JOB_INIT, rs: 1'b0, value: 8'h00};
            default:     push_job = '{kind: JOB_BYTE, rs: 1'b0, value: byte_value};
        endcase
    end

endmodule

// ----- sv/lcdnw_queue.sv -----
// ----------------------------------------------------------------------------
// lcdnw_queue
// Two-entry job queue between the request front and the phase sequencer.
// ----------------------------------------------------------------------------
module lcdnw_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lcdnw_pkg::job_t  push_job,
    output logic             full,
    input  logic             pop,
    output lcdnw_pkg::job_t  pop_job,
    output logic             empty
);
    import lcdnw_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ----- sv/lcdnw_back.sv -----
// ----------------------------------------------------------------------------
// lcdnw_back
// Phase sequencer: steps through the phases of one job into the output
// register, one per cycle while out_stall does not hold that register.
// ----------------------------------------------------------------------------
module lcdnw_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lcdnw_pkg::cfg_t                  cfg,
    input  logic                             empty,
    input  lcdnw_pkg::job_t                  pop_job,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             register_select,
    output logic [3:0]                       data_nibble,
    output logic                             enable_level,
    output logic [lcdnw_pkg::TICK_W-1:0]     hold_ticks,
    output logic                             status,
    output logic                             last
);
    import lcdnw_pkg::*;

    back_state_t        state_reg, state_next;
    job_t               job_reg, job_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               out_valid_reg, out_valid_next;
    logic               rs_reg, rs_next;
    logic [3:0]         nib_reg, nib_next;
    logic               en_reg, en_next;
    logic [TICK_W-1:0]  hold_reg, hold_next;
    logic               status_reg, status_next;
    logic               last_reg, last_next;

    phase_t             ph;
    logic [TICK_W-1:0]  ph_hold;
    logic               is_last;
    logic               load_ok;
    logic               emit;

    assign load_ok = !out_valid_reg || !out_stall;
    assign emit    = (state_reg == ST_RUN) && load_ok;

    always_comb
    begin
        case (job_reg.kind)
            JOB_INIT:
            begin
                ph      = init_phase(step_reg);
                is_last = (step_reg == INIT_LAST_STEP);
            end
            JOB_ERROR:
            begin
                ph      = '{rs: 1'b0, nibble: 4'h0, en: 1'b0, hold_sel: HOLD_ZERO};
                is_last = 1'b1;
            end
            default:
            begin
                ph      = byte_phase(job_reg.rs, job_reg.value, step_reg[2:0]);
                is_last = (step_reg == BYTE_LAST_STEP);
            end
        endcase

        case (ph.hold_sel)
            HOLD_PULSE:     ph_hold = cfg.pulse;
            HOLD_SETTLE:    ph_hold = cfg.settle;
            HOLD_LONG:      ph_hold = cfg.long_settle;
            HOLD_POWERUP:   ph_hold = cfg.powerup;
            HOLD_FIRST_GAP: ph_hold = cfg.first_gap;
            HOLD_GAP:       ph_hold = cfg.gap;
            default:        ph_hold = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        rs_next        = rs_reg;
        nib_next       = nib_reg;
        en_next        = en_reg;
        hold_next      = hold_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        pop            = 1'b0;

        if (emit)
        begin
            out_valid_next = 1'b1;
            rs_next        = ph.rs;
            nib_next       = ph.nibble;
            en_next        = ph.en;
            hold_next      = ph_hold;
            status_next    = (job_reg.kind == JOB_ERROR);
            last_next      = is_last;
            step_next      = step_reg + 6'd1;
            if (is_last)
                state_next = ST_IDLE;
        end
        else if (load_ok)
        begin
            out_valid_next = 1'b0;
        end

        // Take the next job when idle or right as the current one finishes.
        if (!empty && ((state_reg == ST_IDLE) || (emit && is_last)))
        begin
            pop        = 1'b1;
            job_next   = pop_job;
            step_next  = '0;
            state_next = ST_RUN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        rs_reg     <= rs_next;
        nib_reg    <= nib_next;
        en_reg     <= en_next;
        hold_reg   <= hold_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign out_valid       = out_valid_reg;
    assign register_select = rs_reg;
    assign data_nibble     = nib_reg;
    assign enable_level    = en_reg;
    assign hold_ticks      = hold_reg;
    assign status          = status_reg;
    assign last            = last_reg;

endmodule

// ----- sv/char_lcd_nibble_write_sequencer.sv -----
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Turns display requests into timed pin phases for a 4-bit character link.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid / in_stall): one beat per request: command
//   byte, data byte, cursor set (row, column) or power-up init.
//   Phase channel (out_valid / out_stall): one beat per pin phase with
//   register select, data nibble, enable level and hold time; last marks
//   the final phase of a request, status flags an out-of-range cursor.
//   Config port (cfg_we / cfg_index / cfg_data): write timing registers
//   while the block is idle; indexes beyond the list are dropped.
// Timing:
//   The front classifies a request in the cycle it is taken and drops it
//   into a two-entry job queue. The back sequencer emits one phase per
//   cycle while out_stall is low: a byte has 5 phases, init 33, a cursor
//   error 1. The first phase passes through the queue entry and the job
//   register into the output register; back-to-back jobs run with no gap.
// Reset: queue empties, output goes invalid, timing registers load defaults.
// Stall: a stalled phase holds; the sequencer waits, the queue fills and
//   then in_stall rises.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer #(
    parameter int ROWS    = 2,
    parameter int COLUMNS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [lcdnw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lcdnw_pkg::TICK_W-1:0]          cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            req_type,
    input  logic [7:0]                            byte_value,
    input  logic [2:0]                            row,
    input  logic [5:0]                            column,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  register_select,
    output logic [3:0]                            data_nibble,
    output logic                                  enable_level,
    output logic [lcdnw_pkg::TICK_W-1:0]          hold_ticks,
    output logic                                  status,
    output logic                                  last
);
    import lcdnw_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  push;
    job_t  push_job;
    logic  full;
    logic  pop;
    job_t  pop_job;
    logic  empty;

    // Timing register file: write one register per beat, drop unknown indexes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_PULSE:     cfg_next.pulse       = cfg_data;
                REG_SETTLE:    cfg_next.settle      = cfg_data;
                REG_LONG:      cfg_next.long_settle = cfg_data;
                REG_POWERUP:   cfg_next.powerup     = cfg_data;
                REG_FIRST_GAP: cfg_next.first_gap   = cfg_data;
                REG_GAP:       cfg_next.gap         = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{pulse: RST_PULSE, settle: RST_SETTLE, long_settle: RST_LONG,
                         powerup: RST_POWERUP, first_gap: RST_FIRST_GAP,
                         gap: RST_GAP};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: classify the request and compute the cursor address.
    lcdnw_front #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .byte_value (byte_value),
        .row        (row),
        .column     (column),
        .push       (push),
        .push_job   (push_job),
        .full       (full)
    );

    // Job queue lets the front keep taking requests while phases drain.
    lcdnw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (empty)
    );

    // Back: walk the phases of each job into the output register.
    lcdnw_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .empty           (empty),
        .pop_job         (pop_job),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .register_select (register_select),
        .data_nibble     (data_nibble),
        .enable_level    (enable_level),
        .hold_ticks      (hold_ticks),
        .status          (status),
        .last            (last)
    );

endmodule
